// ----- sv/tkfs_pkg.sv -----
// shared types and constants for the top-k fitness selector
`default_nettype none

package tkfs_pkg;

  localparam int MAX_ELITE_DEF      = 16;
  localparam int MAX_POPULATION_DEF = 1024;

  localparam int FIT_W     = 32;
  localparam int IDX_OUT_W = 10;
  localparam int ECNT_W    = 5;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // register word index decoded from paddr[2]
  localparam logic REG_ELITE_COUNT = 1'b0;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic insert;     // put the incoming pair into the chain
    logic shift_out;  // move the head into the output register, chain moves up
    logic mark_last;  // head being moved out is the final result
    logic clear;      // drop all entries and restart arrival count
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/tkfs_ctrl.sv -----
// controller: collect/emit sequencing, result count and output valid
`default_nettype none

module tkfs_ctrl
  import tkfs_pkg::*;
#(
  parameter int MAX_ELITE = MAX_ELITE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last_item,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire logic [ECNT_W-1:0] elite_count,
  input  wire logic              next_valid,
  output cmd_t                   cmd
);

  localparam int KW = ($clog2(MAX_ELITE + 1) > ECNT_W) ? $clog2(MAX_ELITE + 1) : ECNT_W;

  state_t        state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [KW-1:0] emitted_r, emitted_nxt;
  logic [KW-1:0] k_ext;
  logic [KW-1:0] k_eff;
  logic          final_one;
  logic          load_ok;

  assign k_ext = KW'(elite_count);

  always_comb begin
    if (k_ext == '0) begin
      k_eff = KW'(1);
    end else if (k_ext > KW'(MAX_ELITE)) begin
      k_eff = KW'(MAX_ELITE);
    end else begin
      k_eff = k_ext;
    end
  end

  // fewer kept entries than requested ends the burst early
  assign final_one = ((emitted_r + KW'(1)) == k_eff) || !next_valid;
  assign load_ok   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      out_valid_r <= 1'b0;
      emitted_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      emitted_r   <= emitted_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    emitted_nxt   = emitted_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_COLLECT: begin
        in_stall   = 1'b0;
        cmd.insert = in_valid;
        if (in_valid && in_last_item) begin
          state_nxt   = ST_EMIT;
          emitted_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          cmd.shift_out = 1'b1;
          cmd.mark_last = final_one;
          out_valid_nxt = 1'b1;
          emitted_nxt   = emitted_r + KW'(1);
          if (final_one) begin
            cmd.clear = 1'b1;
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- sv/tkfs_datapath.sv -----
// datapath: sorted compare-and-shift chain, arrival counter, output register
`default_nettype none

module tkfs_datapath
  import tkfs_pkg::*;
#(
  parameter int MAX_ELITE      = MAX_ELITE_DEF,
  parameter int MAX_POPULATION = MAX_POPULATION_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  input  wire logic signed [FIT_W-1:0] in_fitness,
  output logic                         next_valid,
  output logic [IDX_OUT_W-1:0]         out_elite_index,
  output logic signed [FIT_W-1:0]      out_elite_fitness,
  output logic                         out_last_result
);

  localparam int CNT_W = $clog2(MAX_POPULATION);

  logic signed [FIT_W-1:0] fit_r [MAX_ELITE];
  logic [CNT_W-1:0]        idx_r [MAX_ELITE];
  logic [MAX_ELITE-1:0]    vld_r;
  logic [MAX_ELITE-1:0]    above;
  logic [CNT_W-1:0]        arrival_r, arrival_nxt;

  logic [IDX_OUT_W-1:0]    out_idx_r;
  logic signed [FIT_W-1:0] out_fit_r;
  logic                    out_last_r;
  logic [CNT_W+IDX_OUT_W-1:0] head_idx_wide;

  always_comb begin
    if (arrival_r == CNT_W'(MAX_POPULATION - 1)) begin
      arrival_nxt = '0;
    end else begin
      arrival_nxt = arrival_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r <= '0;
    end else if (cmd.clear) begin
      arrival_r <= '0;
    end else if (cmd.insert) begin
      arrival_r <= arrival_nxt;
    end
  end

  for (genvar g = 0; g < MAX_ELITE; g++) begin : g_cell
    logic signed [FIT_W-1:0] up_fit, dn_fit;
    logic [CNT_W-1:0]        up_idx, dn_idx;
    logic                    up_vld, dn_vld, prev_above;
    logic signed [FIT_W-1:0] fit_nxt;
    logic [CNT_W-1:0]        idx_nxt;
    logic                    vld_nxt;

    // stored pair ranks strictly above the incoming one; ties go to larger index
    assign above[g] = vld_r[g] &&
                      ((fit_r[g] > in_fitness) ||
                       ((fit_r[g] == in_fitness) && (idx_r[g] > arrival_r)));

    if (g == 0) begin : g_head
      assign up_fit     = in_fitness;
      assign up_idx     = arrival_r;
      assign up_vld     = 1'b1;
      assign prev_above = 1'b1;
    end else begin : g_mid
      assign up_fit     = fit_r[g-1];
      assign up_idx     = idx_r[g-1];
      assign up_vld     = vld_r[g-1];
      assign prev_above = above[g-1];
    end

    if (g == MAX_ELITE - 1) begin : g_tail
      assign dn_fit = fit_r[g];
      assign dn_idx = idx_r[g];
      assign dn_vld = 1'b0;
    end else begin : g_body
      assign dn_fit = fit_r[g+1];
      assign dn_idx = idx_r[g+1];
      assign dn_vld = vld_r[g+1];
    end

    always_comb begin
      fit_nxt = fit_r[g];
      idx_nxt = idx_r[g];
      vld_nxt = vld_r[g];
      if (cmd.insert && !above[g]) begin
        if (prev_above) begin
          fit_nxt = in_fitness;
          idx_nxt = arrival_r;
          vld_nxt = 1'b1;
        end else begin
          fit_nxt = up_fit;
          idx_nxt = up_idx;
          vld_nxt = up_vld;
        end
      end else if (cmd.shift_out) begin
        fit_nxt = dn_fit;
        idx_nxt = dn_idx;
        vld_nxt = dn_vld;
      end
      if (cmd.clear) begin
        vld_nxt = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_nxt;
      end
    end

    always_ff @(posedge clk) begin
      fit_r[g] <= fit_nxt;
      idx_r[g] <= idx_nxt;
    end
  end

  if (MAX_ELITE > 1) begin : g_nv
    assign next_valid = vld_r[1];
  end else begin : g_nv1
    assign next_valid = 1'b0;
  end

  assign head_idx_wide = {{IDX_OUT_W{1'b0}}, idx_r[0]};

  always_ff @(posedge clk) begin
    if (cmd.shift_out) begin
      out_idx_r  <= head_idx_wide[IDX_OUT_W-1:0];
      out_fit_r  <= fit_r[0];
      out_last_r <= cmd.mark_last;
    end
  end

  assign out_elite_index   = out_idx_r;
  assign out_elite_fitness = out_fit_r;
  assign out_last_result   = out_last_r;

endmodule

`default_nettype wire

// ----- sv/top_k_fitness_selector.sv -----
// top-k fitness selector: keeps the best entries of a population, reports them in rank order
//
// input channel: one fitness value (signed Q16.16) per transfer, in_valid/in_stall;
//   the arrival position counts from zero in each population and wraps at MAX_POPULATION.
// while a population streams in, one transfer is taken every cycle: each transfer
//   is compared against every kept entry at once and the chain shifts in the same cycle.
// the transfer flagged in_last_item is inserted too; the block then stalls the input and
//   emits min(elite_count, entries kept) results, best first, one per cycle when
//   out_stall is low; out_last_result marks the lowest-ranked one.
// the first result is loaded into the output register from the emit state; the input stays
//   stalled until the final result has been moved out of the chain.
// a stalled result holds in the output register; emission pauses until it is taken,
//   and a new population may start while the final result still waits.
// after the final result is moved out the chain and arrival count clear.
// ties on fitness go to the larger arrival position.
// config: elite_count at byte address 0 (0 acts as 1, above MAX_ELITE acts as MAX_ELITE);
//   write it only while no population is in flight.
// reset (rst_n low, synchronous): chain empty, arrival count zero, elite_count = 1.
`default_nettype none

module top_k_fitness_selector
  import tkfs_pkg::*;
#(
  parameter int MAX_ELITE      = MAX_ELITE_DEF,
  parameter int MAX_POPULATION = MAX_POPULATION_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [FIT_W-1:0] in_fitness,
  input  wire logic                    in_last_item,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [IDX_OUT_W-1:0]         out_elite_index,
  output logic signed [FIT_W-1:0]      out_elite_fitness,
  output logic                         out_last_result,
  input  wire logic                    cfg_psel,
  input  wire logic                    cfg_penable,
  input  wire logic                    cfg_pwrite,
  input  wire logic [APB_AW-1:0]       cfg_paddr,
  input  wire logic [APB_DW-1:0]       cfg_pwdata,
  output logic [APB_DW-1:0]            cfg_prdata,
  output logic                         cfg_pready
);

  logic [ECNT_W-1:0] elite_count_r;
  logic              cfg_wr;
  logic              next_valid;
  cmd_t              cmd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elite_count_r <= ECNT_W'(1);
    end else if (cfg_wr && (cfg_paddr[2] == REG_ELITE_COUNT)) begin
      elite_count_r <= cfg_pwdata[ECNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[2])
      REG_ELITE_COUNT: cfg_prdata = APB_DW'(elite_count_r);
      default:         cfg_prdata = '0;
    endcase
  end

  tkfs_ctrl #(
    .MAX_ELITE (MAX_ELITE)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .elite_count  (elite_count_r),
    .next_valid   (next_valid),
    .cmd          (cmd)
  );

  tkfs_datapath #(
    .MAX_ELITE      (MAX_ELITE),
    .MAX_POPULATION (MAX_POPULATION)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_fitness        (in_fitness),
    .next_valid        (next_valid),
    .out_elite_index   (out_elite_index),
    .out_elite_fitness (out_elite_fitness),
    .out_last_result   (out_last_result)
  );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench for the top-k fitness selector: directed table, random populations, predictor
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tkfs_pkg::*;

  localparam int MAX_ELITE   = MAX_ELITE_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_CYCLES = 150;
  localparam int NO_CFG      = -1;
  localparam logic [APB_AW-1:0] ELITE_ADDR = {REG_ELITE_COUNT, 2'b00};

  typedef struct packed {
    logic [IDX_OUT_W-1:0]    idx;
    logic signed [FIT_W-1:0] fit;
    logic                    last;
  } elite_t;

  // cfg: elite_count to write before the row, or NO_CFG; typed rows carry their single result
  typedef struct packed {
    int                      cfg;
    logic signed [FIT_W-1:0] fit;
    logic                    last;
    logic                    typed;
    logic [IDX_OUT_W-1:0]    x_idx;
    logic signed [FIT_W-1:0] x_fit;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [FIT_W-1:0] in_fitness = '0;
  logic in_last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_OUT_W-1:0] out_elite_index;
  logic signed [FIT_W-1:0] out_elite_fitness;
  logic out_last_result;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  // predictor state
  logic signed [FIT_W-1:0] kept_fit [MAX_ELITE];
  logic [IDX_OUT_W-1:0] kept_idx [MAX_ELITE];
  bit kept_used [MAX_ELITE] = '{default: 1'b0};
  logic [IDX_OUT_W-1:0] arrival_pos = '0;
  logic [ECNT_W-1:0] elite_count_q = ECNT_W'(1);
  elite_t ranked_out [MAX_ELITE];

  elite_t elite_q [$];
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_out = 1'b0;

  row_t dir_rows [20] = '{
    '{NO_CFG, 32'h7FFFFFFF, 1'b1, 1'b1, 10'd0, 32'h7FFFFFFF},
    '{NO_CFG, 32'h80000000, 1'b1, 1'b1, 10'd0, 32'h80000000},
    '{NO_CFG, 32'h00000000, 1'b0, 1'b0, 10'd0, 32'h0},
    '{NO_CFG, 32'h00000000, 1'b1, 1'b1, 10'd1, 32'h0},
    '{NO_CFG, 32'hFFFFFFFF, 1'b0, 1'b0, 10'd0, 32'h0},
    '{NO_CFG, 32'h00000001, 1'b0, 1'b0, 10'd0, 32'h0},
    '{NO_CFG, 32'h80000000, 1'b1, 1'b1, 10'd1, 32'h00000001},
    '{0,      32'h00010000, 1'b0, 1'b0, 10'd0, 32'h0},
    '{NO_CFG, 32'h00018000, 1'b1, 1'b1, 10'd1, 32'h00018000},
    '{16,     32'h12345678, 1'b0, 1'b0, 10'd0, 32'h0},
    '{NO_CFG, 32'hEDCBA987, 1'b0, 1'b0, 10'd0, 32'h0},
    '{NO_CFG, 32'h12345678, 1'b0, 1'b0, 10'd0, 32'h0},
    '{NO_CFG, 32'h7FFFFFFF, 1'b1, 1'b0, 10'd0, 32'h0},
    '{31,     32'h55555555, 1'b0, 1'b0, 10'd0, 32'h0},
    '{NO_CFG, 32'hAAAAAAAA, 1'b1, 1'b0, 10'd0, 32'h0},
    '{2,      32'h00000005, 1'b0, 1'b0, 10'd0, 32'h0},
    '{NO_CFG, 32'h00000005, 1'b0, 1'b0, 10'd0, 32'h0},
    '{NO_CFG, 32'h00000005, 1'b0, 1'b0, 10'd0, 32'h0},
    '{NO_CFG, 32'hFFFFFFFB, 1'b1, 1'b0, 10'd0, 32'h0},
    '{17,     32'h00000000, 1'b1, 1'b1, 10'd0, 32'h0}
  };

  top_k_fitness_selector i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_fitness        (in_fitness),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_elite_index   (out_elite_index),
    .out_elite_fitness (out_elite_fitness),
    .out_last_result   (out_last_result),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // higher fitness wins, equal fitness goes to the later arrival
  function automatic bit outranks(input logic signed [FIT_W-1:0] fa,
                                  input logic [IDX_OUT_W-1:0] ia,
                                  input logic signed [FIT_W-1:0] fb,
                                  input logic [IDX_OUT_W-1:0] ib);
    if (fa != fb) return fa > fb;
    return ia > ib;
  endfunction

  // inserts one fitness into the ranking; on the last one fills ranked_out and returns the count
  function automatic int rank_accept(input logic signed [FIT_W-1:0] fit, input logic last);
    int pos;
    int k;
    int n;
    int i;
    pos = 0;
    while (pos < MAX_ELITE && kept_used[pos] &&
           outranks(kept_fit[pos], kept_idx[pos], fit, arrival_pos))
      pos++;
    if (pos < MAX_ELITE) begin
      for (i = MAX_ELITE - 1; i > pos; i--) begin
        kept_fit[i]  = kept_fit[i-1];
        kept_idx[i]  = kept_idx[i-1];
        kept_used[i] = kept_used[i-1];
      end
      kept_fit[pos]  = fit;
      kept_idx[pos]  = arrival_pos;
      kept_used[pos] = 1'b1;
    end
    arrival_pos++;
    if (!last) return 0;
    k = (elite_count_q == 0) ? 1 :
        (elite_count_q > MAX_ELITE) ? MAX_ELITE : int'(elite_count_q);
    n = 0;
    while (n < k && kept_used[n]) begin
      ranked_out[n] = '{kept_idx[n], kept_fit[n], 1'b0};
      n++;
    end
    if (n > 0) ranked_out[n-1].last = 1'b1;
    for (i = 0; i < MAX_ELITE; i++) kept_used[i] = 1'b0;
    arrival_pos = '0;
    return n;
  endfunction

  function automatic logic signed [FIT_W-1:0] pick_fitness();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 6) return $urandom;
    // a handful of values around zero to force ties
    if (roll < 9) return (FIT_W'($urandom_range(4)) - FIT_W'(2)) << 16;
    return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
  endfunction

  task automatic send_fitness(input logic signed [FIT_W-1:0] fit, input logic last,
                              input logic typed, input elite_t typed_res);
    int n;
    int i;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_fitness   <= fit;
    in_last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = rank_accept(fit, last);
    if (typed) elite_q.push_back(typed_res);
    else for (i = 0; i < n; i++) elite_q.push_back(ranked_out[i]);
  endtask

  task automatic send_population(input int len);
    int i;
    for (i = 0; i < len; i++) send_fitness(pick_fitness(), i == len - 1, 1'b0, '0);
  endtask

  task automatic drain(input int settle);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (elite_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  // write elite_count while idle, then read it back
  task automatic set_elite_count(input logic [ECNT_W-1:0] value);
    logic [APB_DW-1:0] wdata;
    drain(4);
    wdata = $urandom;
    wdata[ECNT_W-1:0] = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ELITE_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    elite_count_q = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[ECNT_W-1:0] !== value) begin
      $display("%0t: elite_count read expected %0d got %0d", $time, value,
               cfg_prdata[ECNT_W-1:0]);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    elite_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (elite_q.size() == 0) begin
        $display("%0t: unexpected result: expected none got index %0d fitness %h last %b",
                 $time, out_elite_index, out_elite_fitness, out_last_result);
        errors++;
      end else begin
        want = elite_q.pop_front();
        if (out_elite_index !== want.idx) begin
          $display("%0t: elite_index expected %0d got %0d", $time, want.idx, out_elite_index);
          errors++;
        end
        if (out_elite_fitness !== want.fit) begin
          $display("%0t: elite_fitness expected %h got %h", $time, want.fit, out_elite_fitness);
          errors++;
        end
        if (out_last_result !== want.last) begin
          $display("%0t: last_result expected %b got %b", $time, want.last, out_last_result);
          errors++;
        end
      end
    end
    out_stall <= hold_out || ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    elite_t typed_res;
    int r;
    int ph;
    int n_sent;
    int len;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows run with the reset value of elite_count until the first write
    for (r = 0; r < 20; r++) begin
      if (dir_rows[r].cfg != NO_CFG) set_elite_count(ECNT_W'(dir_rows[r].cfg));
      typed_res = '{dir_rows[r].x_idx, dir_rows[r].x_fit, 1'b1};
      send_fitness(dir_rows[r].fit, dir_rows[r].last, dir_rows[r].typed, typed_res);
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_elite_count(ECNT_W'(1));
        1: set_elite_count(ECNT_W'(16));
        2: set_elite_count(ECNT_W'(31));
        default: set_elite_count(ECNT_W'($urandom_range(2, 15)));
      endcase
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      n_sent = 0;
      while (n_sent < 12) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
        send_population(len);
        n_sent += len;
      end
    end

    // long output hold-off while populations keep coming
    set_elite_count(ECNT_W'(16));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
      begin
        repeat (2) send_population(12);
      end
    join

    drain(20);
    if (elite_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived, next index %0d fitness %h", $time,
               elite_q.size(), elite_q[0].idx, elite_q[0].fit);
      errors++;
    end
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/tkfs_pkg.sv
sv/tkfs_ctrl.sv
sv/tkfs_datapath.sv
sv/top_k_fitness_selector.sv
sim/testbench.sv
